[hdl/scpa_pkg.sv]
// scpa_pkg: shared constants, types and helper functions of the size-class pool allocator.
// No dependencies; imported by scpa_ctrl, scpa_dp and the top level.
package scpa_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int MAX_CELLS   = 256;
    localparam int STEP_BYTES  = 4;
    localparam int MAX_STEPS   = 16;
    localparam int WORDS       = (MAX_CELLS + 31) / 32;
    localparam int MEM_DEPTH   = NUM_CLASSES * WORDS;
    localparam int CLS_W       = 2;
    localparam int WRD_W       = 3;
    localparam int ADDR_W      = CLS_W + WRD_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_AWR,
        S_PUSH,
        S_FIND,
        S_DIV,
        S_RRD,
        S_RWR
    } t_state;

    typedef struct packed {
        logic       latch;
        logic       pick;
        logic       awr;
        logic       push;
        logic       find;
        logic       div_go;
        logic [2:0] div_k;
        logic       rrd;
        logic       rwr;
    } t_dp_cmd;

    typedef struct packed {
        logic pick_hit;
        logic find_hit;
        logic out_free;
        logic cfg_settle;
    } t_dp_sts;

    function automatic logic [4:0] eff_steps(input logic [4:0] s);
        return (s > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) : s;
    endfunction

    function automatic logic [8:0] eff_cells(input logic [8:0] n);
        return (n > 9'(MAX_CELLS)) ? 9'(MAX_CELLS) : n;
    endfunction

    // words holding at least one real cell
    function automatic logic [7:0] real_words(input logic [8:0] cells);
        logic [9:0] nw;
        logic [7:0] m;
        nw = (10'(cells) + 10'd31) >> 5;
        for (int i = 0; i < 8; i++) begin
            m[i] = (10'(i) < nw);
        end
        return m;
    endfunction

    // cells of word w that exist
    function automatic logic [31:0] real_cells(input logic [8:0] cells, input logic [2:0] w);
        logic [31:0] m;
        for (int i = 0; i < 32; i++) begin
            m[i] = ({2'b00, w, 5'b0} + 10'(i)) < {1'b0, cells};
        end
        return m;
    endfunction

    function automatic logic [2:0] lowest8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) r = 3'(i);
        end
        return r;
    endfunction

    function automatic logic [4:0] lowest32(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

endpackage

[hdl/scpa_req_if.sv]
// scpa_req_if: request channel (alloc/release beats), valid/ready handshake.
// No dependencies.
interface scpa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [6:0]  request_bytes;
    logic [15:0] cell_offset;

    modport source (output valid, cmd, request_bytes, cell_offset, input ready);
    modport sink   (input valid, cmd, request_bytes, cell_offset, output ready);
endinterface

[hdl/scpa_rsp_if.sv]
// scpa_rsp_if: response channel (alloc result beats), valid/ready handshake.
// No dependencies.
interface scpa_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] granted_offset;
    logic [1:0]  class_used;

    modport source (output valid, ok, granted_offset, class_used, input ready);
    modport sink   (input valid, ok, granted_offset, class_used, output ready);
endinterface

[hdl/scpa_ram.sv]
// scpa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module scpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/scpa_ctrl.sv]
// scpa_ctrl: sequencer of the allocator; drives datapath commands from its status.
// Depends on scpa_pkg.
module scpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    input  scpa_pkg::t_dp_sts i_sts,
    output scpa_pkg::t_dp_cmd o_cmd
);
    import scpa_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // class bases are refreshing right after a config write
                o_in_ready = !i_sts.cfg_settle;
                if (i_in_valid && !i_sts.cfg_settle) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_in_cmd == CMD_RELEASE) ? S_FIND : S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = i_sts.pick_hit ? S_AWR : S_PUSH;
            end
            S_AWR: begin
                o_cmd.awr = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_k = 3'd7;
                n_state = i_sts.find_hit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                o_cmd.div_k  = r_k;
                n_k = r_k - 3'd1;
                if (r_k == 3'd0) n_state = S_RRD;
            end
            S_RRD: begin
                o_cmd.rrd = 1'b1;
                n_state = S_RWR;
            end
            S_RWR: begin
                o_cmd.rwr = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_k == 3'd0) |=> r_state == S_RRD)
        else $error("divider did not hand over to read");
    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && i_sts.out_free) |=> r_state == S_IDLE)
        else $error("result pushed but sequencer not idle");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_PICK || r_state == S_FIND))
        else $error("accepted beat did not start work");
endmodule

[hdl/scpa_dp.sv]
// scpa_dp: allocator datapath: config registers, mark bitmaps, offset math, divider, result reg.
// Depends on scpa_pkg and scpa_ram.
module scpa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scpa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [scpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [6:0]                          i_request_bytes,
    input  logic [15:0]                         i_cell_offset,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_ok,
    output logic [15:0]                         o_granted_offset,
    output logic [1:0]                          o_class_used,
    input  scpa_pkg::t_dp_cmd                   i_cmd,
    output scpa_pkg::t_dp_sts                   o_sts
);
    import scpa_pkg::*;

    logic [4:0]  r_size  [NUM_CLASSES];
    logic [8:0]  r_count [NUM_CLASSES];
    logic [14:0] r_span  [NUM_CLASSES];
    logic [15:0] r_base  [NUM_CLASSES];
    logic [7:0]  r_full  [NUM_CLASSES];
    logic [MEM_DEPTH-1:0] r_vld;
    logic        r_rvld;
    logic        r_cfg_settle;
    logic [6:0]  r_req;
    logic [15:0] r_off;
    logic [CLS_W-1:0] r_cls;
    logic [WRD_W-1:0] r_w;
    logic [12:0] r_rem;
    logic [4:0]  r_dvs;
    logic [7:0]  r_quo;
    logic        r_res_ok;
    logic [15:0] r_res_off;
    logic [1:0]  r_res_cls;
    logic        r_out_vld;
    logic        r_out_ok;
    logic [15:0] r_out_off;
    logic [1:0]  r_out_cls;

    logic [6:0]  bytes_c [NUM_CLASSES];
    logic [8:0]  cells_c [NUM_CLASSES];
    logic [15:0] base_c  [NUM_CLASSES];
    logic        pick_hit;
    logic [CLS_W-1:0] pick_cls;
    logic [WRD_W-1:0] pick_w;
    logic        find_hit;
    logic [CLS_W-1:0] find_cls;
    logic [15:0] find_rel;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic        mem_we;
    logic [31:0] mem_wdata, mem_rdata, word;
    logic [31:0] real_m, free_m, set_word;
    logic [4:0]  bit_b;
    logic [14:0] prod;
    logic [12:0] trial;
    logic        out_free;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            bytes_c[c] = {eff_steps(r_size[c]), 2'b00};
            cells_c[c] = eff_cells(r_count[c]);
        end
    end

    // running sum of spans: base of each class
    always_comb begin
        base_c[0] = '0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            base_c[c] = base_c[c-1] + 16'(r_span[c-1]);
        end
    end

    // first class in order whose cell fits and that has a non-full word; zero or > last class size misses
    always_comb begin
        logic [7:0] avail;
        pick_hit = 1'b0;
        pick_cls = '0;
        pick_w   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            avail = ~r_full[c] & real_words(cells_c[c]);
            if (bytes_c[c] >= r_req && avail != 8'd0) begin
                pick_hit = 1'b1;
                pick_cls = CLS_W'(c);
                pick_w   = lowest8(avail);
            end
        end
        if (r_req == 7'd0 || r_req > bytes_c[NUM_CLASSES-1]) pick_hit = 1'b0;
    end

    always_comb begin
        find_hit = 1'b0;
        find_cls = '0;
        find_rel = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_span[c] != 15'd0 && r_off >= r_base[c]
                && (r_off - r_base[c]) < {1'b0, r_span[c]}) begin
                find_hit = 1'b1;
                find_cls = CLS_W'(c);
                find_rel = r_off - r_base[c];
            end
        end
    end

    assign word     = r_rvld ? mem_rdata : 32'd0;
    assign real_m   = real_cells(cells_c[r_cls], r_w);
    assign free_m   = ~word & real_m;
    assign bit_b    = lowest32(free_m);
    assign set_word = word | (32'd1 << bit_b);
    assign prod     = 15'({r_w, bit_b} * bytes_c[r_cls]);
    assign trial    = 13'({8'd0, r_dvs} << i_cmd.div_k);
    assign out_free = !r_out_vld || i_out_ready;

    assign mem_raddr = i_cmd.rrd ? {r_cls, r_quo[7:5]} : {pick_cls, pick_w};
    assign mem_we    = i_cmd.awr || i_cmd.rwr;
    assign mem_waddr = i_cmd.awr ? {r_cls, r_w} : {r_cls, r_quo[7:5]};
    assign mem_wdata = i_cmd.awr ? set_word : (word & ~(32'd1 << r_quo[4:0]));

    scpa_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_marks (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // config registers and marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size[0] <= 5'd1;
            r_size[1] <= 5'd2;
            r_size[2] <= 5'd4;
            r_size[3] <= 5'd16;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_count[c] <= 9'd64;
                r_full[c]  <= '0;
            end
            r_vld <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx < CFG_IDX_W'(NUM_CLASSES))
                r_size[i_cfg_idx[CLS_W-1:0]] <= i_cfg_data[4:0];
            else
                r_count[i_cfg_idx[CLS_W-1:0]] <= i_cfg_data;
            for (int c = 0; c < NUM_CLASSES; c++) r_full[c] <= '0;
            r_vld <= '0;
        end else if (i_cmd.awr) begin
            r_vld[{r_cls, r_w}] <= 1'b1;
            if ((set_word & real_m) == real_m) r_full[r_cls][r_w] <= 1'b1;
        end else if (i_cmd.rwr) begin
            r_vld[{r_cls, r_quo[7:5]}] <= 1'b1;
            r_full[r_cls][r_quo[7:5]]  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg_settle <= 1'b0;
        else r_cfg_settle <= i_cfg_we;
    end

    // class spans registered from the config registers; bases registered from the spans, two stages behind
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            r_span[c] <= 15'(bytes_c[c] * cells_c[c]);
            r_base[c] <= base_c[c];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_vld[mem_raddr];
        if (i_cmd.latch) begin
            r_req <= i_request_bytes;
            r_off <= i_cell_offset;
        end
        if (i_cmd.pick) begin
            r_cls     <= pick_cls;
            r_w       <= pick_w;
            r_res_ok  <= 1'b0;
            r_res_off <= '0;
            r_res_cls <= '0;
        end
        if (i_cmd.awr) begin
            r_res_ok  <= 1'b1;
            r_res_off <= r_base[r_cls] + 16'(prod);
            r_res_cls <= r_cls;
        end
        if (i_cmd.find) begin
            r_cls <= find_cls;
            r_rem <= find_rel[14:2];
            r_dvs <= eff_steps(r_size[find_cls]);
            r_quo <= '0;
        end
        // restoring division, one quotient bit per beat from the top
        if (i_cmd.div_go && r_rem >= trial) begin
            r_rem <= r_rem - trial;
            r_quo[i_cmd.div_k] <= 1'b1;
        end
        if (i_cmd.push && out_free) begin
            r_out_ok  <= r_res_ok;
            r_out_off <= r_res_off;
            r_out_cls <= r_res_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (i_cmd.push && out_free) r_out_vld <= 1'b1;
        else if (i_out_ready) r_out_vld <= 1'b0;
    end

    assign o_out_valid      = r_out_vld;
    assign o_ok             = r_out_ok;
    assign o_granted_offset = r_out_off;
    assign o_class_used     = r_out_cls;
    assign o_sts.pick_hit   = pick_hit;
    assign o_sts.find_hit   = find_hit;
    assign o_sts.out_free   = out_free;
    assign o_sts.cfg_settle = r_cfg_settle;

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_vld == '0 && r_full[0] == 8'd0 && r_full[NUM_CLASSES-1] == 8'd0))
        else $error("config write left marks set");
    a_free_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.awr |-> free_m != 32'd0)
        else $error("picked word has no free cell");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.find && find_hit) |-> eff_steps(r_size[find_cls]) != 5'd0)
        else $error("release hit a class with zero cell size");
endmodule

[hdl/size_class_pool_allocator_core.sv]
// size_class_pool_allocator_core: top level, joins sequencer and datapath to the channels.
// Depends on scpa_pkg, scpa_req_if, scpa_rsp_if, scpa_ctrl, scpa_dp.
//
//  channel  | dir | beat
//  i_req    | in  | cmd, request_bytes, cell_offset
//  o_rsp    | out | ok, granted_offset, class_used (alloc only)
//  i_cfg_*  | in  | register write, index 0..7, no read-back
//
// Alloc: from accept through pick, mark write (on a hit only) and push to the result register;
// push waits while the result register is held. Release: match, 8-step divider, read, write.
// One request in flight; i_req.ready is high only when the sequencer is idle.
// i_req.ready stays low for the cycle after a config write while class bases refresh.
// Synchronous active-low reset clears all marks; so does every config write.
module size_class_pool_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    scpa_req_if.sink                        i_req,
    scpa_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [scpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [scpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scpa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    scpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_cmd   (i_req.cmd),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scpa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_request_bytes  (i_req.request_bytes),
        .i_cell_offset    (i_req.cell_offset),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_ok             (o_rsp.ok),
        .o_granted_offset (o_rsp.granted_offset),
        .o_class_used     (o_rsp.class_used),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );
endmodule
